// ===== src/hpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg : shared types, constants and hash helpers
// constants, table request struct, sequencer states and the group/tag
// functions used by the hashed page table engine
// ----------------------------------------------------------------------------
package hpt_pkg;

  // table geometry
  localparam int unsigned MaskBits    = 2;
  localparam int unsigned LowHashBits = 10;
  localparam int unsigned HashW       = 19;
  localparam int unsigned GroupW      = LowHashBits + MaskBits;
  localparam int unsigned SlotW       = 3;
  localparam int unsigned AddrW       = GroupW + SlotW;
  localparam int unsigned NumEntries  = 1 << AddrW;
  localparam int unsigned EntryW      = 64;
  localparam int unsigned WordW       = 32;
  localparam int unsigned SlotCntW    = SlotW + 2;
  localparam int unsigned CountW      = 5;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_MASK   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TABLE_ENABLE = 1'b1;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // tag word bits
  localparam logic [WordW-1:0] TagValid = 32'h8000_0000;
  localparam logic [WordW-1:0] TagSec   = 32'h0000_0040;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INSERT,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [EntryW-1:0] wdata;
    logic              re;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

  // primary group: low hash bits direct, upper bits under the mask
  function automatic logic [GroupW-1:0] primary_group(
    input logic [31:0]         vaddr,
    input logic [19:0]         vsid,
    input logic [MaskBits-1:0] mask
  );
    logic [HashW-1:0] hash;
    hash = vsid[HashW-1:0] ^ {3'b000, vaddr[27:12]};
    return {hash[LowHashBits +: MaskBits] & mask, hash[LowHashBits-1:0]};
  endfunction

  // secondary group: complement of the primary index within the span
  function automatic logic [GroupW-1:0] secondary_group(
    input logic [GroupW-1:0]   grp,
    input logic [MaskBits-1:0] mask
  );
    return {~grp[GroupW-1:LowHashBits] & mask, ~grp[LowHashBits-1:0]};
  endfunction

  // valid, vaddr[31:28], vsid, H clear, api
  function automatic logic [WordW-1:0] flush_tag(
    input logic [31:0] vaddr,
    input logic [19:0] vsid
  );
    return {1'b1, vaddr[31:28], vsid, 1'b0, vaddr[27:22]};
  endfunction

endpackage
`default_nettype wire

// ===== src/hpt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_ram : page table storage
// one write and one read port, registered read data
// ----------------------------------------------------------------------------
module hpt_ram (
  input  wire logic                      clk_i,
  input  wire hpt_pkg::mem_req_t         req_i,
  output logic [hpt_pkg::EntryW-1:0]     rdata_o
);

  logic [hpt_pkg::EntryW-1:0] mem [hpt_pkg::NumEntries];
  logic [hpt_pkg::EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/hpt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_ctrl : sequencer with shared tag compare and counter
// clears the table after reset, writes inserts, and walks the sixteen
// slots of a flush through one compare unit
// ----------------------------------------------------------------------------
module hpt_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [31:0]                   virt_addr_i,
  input  wire logic [19:0]                   seg_id_i,
  input  wire logic [31:0]                   entry_high_i,
  input  wire logic [31:0]                   entry_low_i,
  input  wire logic [hpt_pkg::CfgDataW-1:0]  table_mask_i,
  input  wire logic                          table_enable_i,
  output hpt_pkg::mem_req_t                  mem_req_o,
  input  wire logic [hpt_pkg::EntryW-1:0]    mem_rdata_i,
  input  wire logic                          out_free_i,
  output logic                               done_o,
  output logic [hpt_pkg::CountW-1:0]         count_o
);

  hpt_pkg::state_e state_q, state_d;

  logic [hpt_pkg::AddrW-1:0]    clr_addr_q, clr_addr_d;
  logic [hpt_pkg::GroupW-1:0]   grp_q, grp_d;
  logic [hpt_pkg::GroupW-1:0]   sec_q, sec_d;
  logic [hpt_pkg::WordW-1:0]    tag_q, tag_d;
  logic [hpt_pkg::WordW-1:0]    hi_q, hi_d;
  logic [hpt_pkg::WordW-1:0]    lo_q, lo_d;
  logic [hpt_pkg::SlotCntW-1:0] slot_q, slot_d;
  logic                         chk_q, chk_d;
  logic                         chk_sec_q, chk_sec_d;
  logic [hpt_pkg::AddrW-1:0]    chk_addr_q, chk_addr_d;
  logic [hpt_pkg::CountW-1:0]   cnt_q, cnt_d;

  logic                         accept;
  logic                         issue;
  logic                         hit;
  logic [hpt_pkg::WordW-1:0]    cmp_tag;
  logic [hpt_pkg::GroupW-1:0]   in_grp;
  logic [hpt_pkg::AddrW-1:0]    issue_addr;

  assign in_ready_o = (state_q == hpt_pkg::ST_IDLE);
  assign accept  = in_valid_i && in_ready_o;
  assign in_grp  = hpt_pkg::primary_group(virt_addr_i, seg_id_i,
                                          table_mask_i[hpt_pkg::MaskBits-1:0]);
  assign issue   = (state_q == hpt_pkg::ST_FLUSH) && !slot_q[hpt_pkg::SlotW+1];
  assign issue_addr = {slot_q[hpt_pkg::SlotW] ? sec_q : grp_q,
                       slot_q[hpt_pkg::SlotW-1:0]};
  assign cmp_tag = chk_sec_q ? (tag_q | hpt_pkg::TagSec) : tag_q;
  assign hit     = chk_q && (mem_rdata_i[hpt_pkg::EntryW-1:hpt_pkg::WordW] == cmp_tag);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hpt_pkg::ST_CLEAR: begin
        if (&clr_addr_q) state_d = hpt_pkg::ST_IDLE;
      end
      hpt_pkg::ST_IDLE: begin
        if (accept) begin
          if (op_i == hpt_pkg::OP_INSERT) state_d = hpt_pkg::ST_INSERT;
          else if (table_enable_i)        state_d = hpt_pkg::ST_FLUSH;
          else                            state_d = hpt_pkg::ST_DONE;
        end
      end
      hpt_pkg::ST_INSERT: state_d = hpt_pkg::ST_DONE;
      hpt_pkg::ST_FLUSH: begin
        if (slot_q[hpt_pkg::SlotW+1] && !chk_q) state_d = hpt_pkg::ST_DONE;
      end
      hpt_pkg::ST_DONE: begin
        if (out_free_i) state_d = hpt_pkg::ST_IDLE;
      end
      default: state_d = hpt_pkg::ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_addr_d = clr_addr_q;
    grp_d      = grp_q;
    sec_d      = sec_q;
    tag_d      = tag_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    slot_d     = slot_q;
    chk_d      = 1'b0;
    chk_sec_d  = chk_sec_q;
    chk_addr_d = chk_addr_q;
    cnt_d      = cnt_q;
    mem_req_o  = '0;
    done_o     = 1'b0;

    unique case (state_q)
      hpt_pkg::ST_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_addr_q;
        clr_addr_d      = clr_addr_q + 1'b1;
      end
      hpt_pkg::ST_IDLE: begin
        if (accept) begin
          grp_d  = in_grp;
          sec_d  = hpt_pkg::secondary_group(in_grp, table_mask_i[hpt_pkg::MaskBits-1:0]);
          tag_d  = hpt_pkg::flush_tag(virt_addr_i, seg_id_i);
          hi_d   = entry_high_i;
          lo_d   = entry_low_i;
          slot_d = '0;
          cnt_d  = '0;
        end
      end
      hpt_pkg::ST_INSERT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = {grp_q, {hpt_pkg::SlotW{1'b0}}};
        mem_req_o.wdata = {hi_q, lo_q};
      end
      hpt_pkg::ST_FLUSH: begin
        // read slot k while slot k-1 is compared and written back
        if (issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = issue_addr;
          chk_d           = 1'b1;
          chk_sec_d       = slot_q[hpt_pkg::SlotW];
          chk_addr_d      = issue_addr;
          slot_d          = slot_q + 1'b1;
        end
        if (hit) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = chk_addr_q;
          mem_req_o.wdata = {{hpt_pkg::WordW{1'b0}}, mem_rdata_i[hpt_pkg::WordW-1:0]};
          cnt_d           = cnt_q + 1'b1;
        end
      end
      hpt_pkg::ST_DONE: begin
        done_o = out_free_i;
      end
      default: ;
    endcase
  end

  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= hpt_pkg::ST_CLEAR;
      clr_addr_q <= '0;
      chk_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      chk_q      <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q      <= grp_d;
    sec_q      <= sec_d;
    tag_q      <= tag_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    slot_q     <= slot_d;
    chk_sec_q  <= chk_sec_d;
    chk_addr_q <= chk_addr_d;
    cnt_q      <= cnt_d;
  end

endmodule
`default_nettype wire

// ===== src/hashed_page_table_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_page_table_engine : hashed page table insert and flush
// holds a table of 8-entry groups and answers each request with one beat
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries one request per beat:
//   op_i selects insert (write slot 0 of the primary group) or flush
//   (clear matching tags in the primary group, then H-tagged ones in the
//   secondary group). the output channel (out_valid_o / out_ready_i)
//   returns cleared_count_o for every request, 0 for an insert.
//   one request is handled at a time; in_ready_o is low while busy.
//   an insert writes slot 0 and then registers its result; a flush reads
//   the sixteen slots through the single table read port, one per cycle
//   with compare and write-back overlapped, then does the last compare,
//   settles and registers its result; a disabled flush goes straight to
//   its result. a new request is taken only after the last result has
//   entered the output register. a result waits there while the receiver
//   stalls; the next request is taken meanwhile but finishes only once
//   that slot frees. after reset a clearing pass zeroes the table, one
//   entry a cycle, over all 32768 entries; in_ready_o stays low until it
//   ends. configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are taken
//   at any time: index 0 is table_mask (reset 0), index 1 is table_enable
//   (reset 1).
// ----------------------------------------------------------------------------
module hashed_page_table_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [hpt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hpt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [31:0]                   virt_addr_i,
  input  wire logic [19:0]                   seg_id_i,
  input  wire logic [31:0]                   entry_high_i,
  input  wire logic [31:0]                   entry_low_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hpt_pkg::CountW-1:0]         cleared_count_o
);

  // configuration registers
  logic [hpt_pkg::CfgDataW-1:0] table_mask_q;
  logic                         table_enable_q;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [hpt_pkg::CountW-1:0]   count_q, count_d;

  // sequencer and table
  hpt_pkg::mem_req_t            mem_req;
  logic [hpt_pkg::EntryW-1:0]   mem_rdata;
  logic                         done;
  logic [hpt_pkg::CountW-1:0]   done_count;
  logic                         out_free;

  // slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_mask_q   <= '0;
      table_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hpt_pkg::CFG_TABLE_MASK:   table_mask_q   <= cfg_wdata_i;
        hpt_pkg::CFG_TABLE_ENABLE: table_enable_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  hpt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .virt_addr_i    (virt_addr_i),
    .seg_id_i       (seg_id_i),
    .entry_high_i   (entry_high_i),
    .entry_low_i    (entry_low_i),
    .table_mask_i   (table_mask_q),
    .table_enable_i (table_enable_q),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata),
    .out_free_i     (out_free),
    .done_o         (done),
    .count_o        (done_count)
  );

  hpt_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // result beat register
  always_comb begin
    out_valid_d = out_valid_q;
    count_d     = count_q;
    if (done) begin
      out_valid_d = 1'b1;
      count_d     = done_count;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cleared_count_o = count_q;

endmodule
`default_nettype wire

// ===== src/hpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_checker : port-level checks for the page table engine
// watches both channels and the result range
// ----------------------------------------------------------------------------
module hpt_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [hpt_pkg::CountW-1:0]  cleared_count_o
);

  // held result beat keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cleared_count_o))
    else $error("result beat changed while stalled");

  // at most two full groups can be cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cleared_count_o <= 5'd16)
    else $error("cleared count out of range");

  // one request at a time: busy right after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");

  // a request taken while no result is held does not raise a result beat at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result beat appeared without work");

endmodule

bind hashed_page_table_engine hpt_checker u_hpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .cleared_count_o (cleared_count_o)
);
`default_nettype wire

// ===== tb/sv/tb_hashed_page_table_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hashed_page_table_engine : self-checking bench for the page table engine
// drives insert and flush requests over the valid/ready input channel, keeps
// a shadow copy of the hashed table to work out each cleared count, and
// compares every result beat in order under several mask/enable settings
// and sender/receiver idling patterns
// ----------------------------------------------------------------------------
module tb_hashed_page_table_engine;

  localparam int WatchdogLimit = 150000;  // clearing pass after reset covers 32768 entries
  localparam int SettleCycles  = 24;      // margin over the longest flush
  localparam int KeyPool       = 8;

  // clock and dut ports, inputs driven to known values from time zero
  logic                         clk_i;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_we_i     = 1'b0;
  logic [hpt_pkg::CfgIdxW-1:0]  cfg_idx_i    = hpt_pkg::CFG_TABLE_MASK;
  logic [hpt_pkg::CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic                         op_i         = hpt_pkg::OP_INSERT;
  logic [31:0]                  virt_addr_i  = '0;
  logic [19:0]                  seg_id_i     = '0;
  logic [31:0]                  entry_high_i = '0;
  logic [31:0]                  entry_low_i  = '0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic [hpt_pkg::CountW-1:0]   cleared_count_o;

  // shadow state of the block
  bit   [hpt_pkg::EntryW-1:0]   shadow_table [hpt_pkg::NumEntries];
  logic [hpt_pkg::MaskBits-1:0] mask_q   = '0;
  logic                         enable_q = 1'b1;

  // cleared counts still owed by the block, oldest first
  logic [hpt_pkg::CountW-1:0]   pending_counts [$];

  int error_count    = 0;
  int beats_seen     = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // working set of (address, segment) pairs so flushes hit earlier inserts
  logic [31:0] pool_va   [KeyPool];
  logic [19:0] pool_vsid [KeyPool];

  hashed_page_table_engine i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .virt_addr_i     (virt_addr_i),
    .seg_id_i        (seg_id_i),
    .entry_high_i    (entry_high_i),
    .entry_low_i     (entry_low_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cleared_count_o (cleared_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // tag word: valid, vaddr[31:28], segment id, H clear, api
  function automatic logic [31:0] key_tag(input logic [31:0] va, input logic [19:0] vsid);
    return hpt_pkg::TagValid | {1'b0, va[31:28], vsid, 1'b0, va[27:22]};
  endfunction

  // applies one request to the shadow table and returns its cleared count
  function automatic logic [hpt_pkg::CountW-1:0] predict_cleared_count(
    input logic        op,
    input logic [31:0] va,
    input logic [19:0] vsid,
    input logic [31:0] hi,
    input logic [31:0] lo
  );
    logic [18:0]                hash;
    logic [hpt_pkg::GroupW-1:0] prim;
    logic [hpt_pkg::GroupW-1:0] sec;
    logic [31:0]                tag;
    logic [hpt_pkg::AddrW-1:0]  addr;
    logic [hpt_pkg::CountW-1:0] n;
    hash = vsid[18:0] ^ {3'b000, va[27:12]};
    prim = {hash[hpt_pkg::LowHashBits +: hpt_pkg::MaskBits] & mask_q,
            hash[hpt_pkg::LowHashBits-1:0]};
    n    = '0;
    if (op == hpt_pkg::OP_INSERT) begin
      // slot zero of the primary group, written even while disabled
      shadow_table[{prim, 3'b000}] = {hi, lo};
    end else if (enable_q) begin
      tag = key_tag(va, vsid);
      sec = {~prim[hpt_pkg::GroupW-1:hpt_pkg::LowHashBits] & mask_q,
             ~prim[hpt_pkg::LowHashBits-1:0]};
      for (int s = 0; s < 8; s++) begin
        addr = {prim, 3'(s)};
        if (shadow_table[addr][63:32] == tag) begin
          shadow_table[addr][63:32] = '0;  // low word survives a clear
          n++;
        end
      end
      for (int s = 0; s < 8; s++) begin
        addr = {sec, 3'(s)};
        if (shadow_table[addr][63:32] == (tag | hpt_pkg::TagSec)) begin
          shadow_table[addr][63:32] = '0;
          n++;
        end
      end
    end
    return n;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // one request beat; valid stays up into the next call unless a gap is drawn
  task automatic send_request(
    input logic        op,
    input logic [31:0] va,
    input logic [19:0] vsid,
    input logic [31:0] hi,
    input logic [31:0] lo
  );
    in_valid_i   <= 1'b1;
    op_i         <= op;
    virt_addr_i  <= va;
    seg_id_i     <= vsid;
    entry_high_i <= hi;
    entry_low_i  <= lo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_counts.push_back(predict_cleared_count(op, va, vsid, hi, lo));
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // both registers, written back to back once the engine is quiet
  task automatic set_table(input logic [1:0] mask, input logic en);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= hpt_pkg::CFG_TABLE_MASK;
    cfg_wdata_i <= hpt_pkg::CfgDataW'(mask);
    @(posedge clk_i);
    mask_q      = mask[hpt_pkg::MaskBits-1:0];
    cfg_idx_i   <= hpt_pkg::CFG_TABLE_ENABLE;
    cfg_wdata_i <= hpt_pkg::CfgDataW'(en);
    @(posedge clk_i);
    enable_q    = en;
    cfg_we_i    <= 1'b0;
  endtask

  // field extremes, empty flushes, single and double hits, H tag in primary
  task automatic test_field_extremes();
    logic [31:0] va;
    logic [19:0] vsid;
    set_table(2'd0, 1'b1);
    send_request(hpt_pkg::OP_FLUSH, 32'h0, 20'h0, 32'h0, 32'h0);
    send_request(hpt_pkg::OP_INSERT, 32'h0, 20'h0, key_tag(32'h0, 20'h0), 32'hffff_ffff);
    send_request(hpt_pkg::OP_FLUSH, 32'h0, 20'h0, 32'hffff_ffff, 32'hffff_ffff);
    send_request(hpt_pkg::OP_FLUSH, 32'h0, 20'h0, 32'h0, 32'h0);
    va   = 32'hffff_ffff;
    vsid = 20'hf_ffff;
    send_request(hpt_pkg::OP_INSERT, va, vsid, key_tag(va, vsid), 32'h0);
    send_request(hpt_pkg::OP_INSERT, va ^ 32'h00ff_f000, vsid,
                 key_tag(va, vsid) | hpt_pkg::TagSec, $urandom);
    send_request(hpt_pkg::OP_FLUSH, va, vsid, 32'h0, 32'h0);
    // H-tagged word sitting in the primary group must not match
    va   = 32'h1234_5678;
    vsid = 20'h9_abcd;
    send_request(hpt_pkg::OP_INSERT, va, vsid, key_tag(va, vsid) | hpt_pkg::TagSec,
                 32'h5555_aaaa);
    send_request(hpt_pkg::OP_FLUSH, va, vsid, 32'h0, 32'h0);
    send_request(hpt_pkg::OP_INSERT, 32'hffff_ffff, 20'h0, 32'hffff_ffff, 32'h0);
    send_request(hpt_pkg::OP_FLUSH, 32'hffff_ffff, 20'h0, 32'h0, 32'hffff_ffff);
    send_request(hpt_pkg::OP_INSERT, 32'hffff_ffff, 20'h0, 32'h0, 32'h0);
  endtask

  // disabled table: insert still lands, flush finds nothing until re-enabled
  task automatic test_flush_disabled();
    logic [31:0] va;
    logic [19:0] vsid;
    va   = 32'h8765_4321;
    vsid = 20'h0_f0f0;
    set_table(2'd0, 1'b0);
    send_request(hpt_pkg::OP_INSERT, va, vsid, key_tag(va, vsid), 32'hdead_beef);
    send_request(hpt_pkg::OP_FLUSH, va, vsid, 32'h0, 32'h0);
    set_table(2'd0, 1'b1);
    send_request(hpt_pkg::OP_FLUSH, va, vsid, 32'h0, 32'h0);
  endtask

  // upper hash bits move the group as the mask changes
  task automatic test_mask_aliasing();
    logic [31:0] va;
    logic [19:0] vsid;
    va   = 32'h00c0_0000;
    vsid = 20'h0_0000;
    set_table(2'd3, 1'b1);
    send_request(hpt_pkg::OP_INSERT, va, vsid, key_tag(va, vsid), 32'h1);
    set_table(2'd0, 1'b1);
    send_request(hpt_pkg::OP_FLUSH, va, vsid, 32'h0, 32'h0);
    send_request(hpt_pkg::OP_INSERT, va, vsid, key_tag(va, vsid), 32'h2);
    set_table(2'd3, 1'b1);
    send_request(hpt_pkg::OP_FLUSH, va, vsid, 32'h0, 32'h0);
    va   = 32'h5a5a_5000;
    vsid = 20'h3_c3c3;
    set_table(2'd2, 1'b1);
    send_request(hpt_pkg::OP_INSERT, va, vsid, key_tag(va, vsid), 32'h3);
    send_request(hpt_pkg::OP_INSERT, va ^ 32'h00ff_f000, vsid,
                 key_tag(va, vsid) | hpt_pkg::TagSec, 32'h4);
    send_request(hpt_pkg::OP_FLUSH, va, vsid, 32'h0, 32'h0);
  endtask

  // mostly insert/flush pairs on a small key set, the rest pure noise
  task automatic test_random_traffic(
    input int         n,
    input logic [1:0] mask,
    input logic       en,
    input int         snd_pct,
    input int         rcv_pct
  );
    logic [31:0] va;
    logic [19:0] vsid;
    int          k;
    int          pick;
    set_table(mask, en);
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 10) begin
        k            = $urandom_range(KeyPool-1);
        pool_va[k]   = $urandom;
        pool_vsid[k] = 20'($urandom);
      end
      k    = $urandom_range(KeyPool-1);
      va   = pool_va[k];
      vsid = pool_vsid[k];
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_request(hpt_pkg::OP_INSERT, va, vsid, key_tag(va, vsid), $urandom);
      end else if (pick < 45) begin
        // lands on the secondary group of this key, tagged with H
        send_request(hpt_pkg::OP_INSERT,
                     {8'($urandom), va[23:12] ^ 12'hfff, 12'($urandom)},
                     vsid, key_tag(va, vsid) | hpt_pkg::TagSec, $urandom);
      end else if (pick < 80) begin
        send_request(hpt_pkg::OP_FLUSH, va, vsid, $urandom, $urandom);
      end else begin
        send_request(1'($urandom), $urandom, 20'($urandom), $urandom, $urandom);
      end
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  // result side: random back-pressure and in-order compare
  always @(posedge clk_i) begin : result_check
    logic [hpt_pkg::CountW-1:0] want;
    if (out_valid_o && out_ready_i) begin
      beats_seen++;
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("beat %0d with nothing owed, cleared_count %0d",
                                  beats_seen, cleared_count_o));
      end else begin
        want = pending_counts.pop_front();
        if (cleared_count_o !== want)
          report_mismatch($sformatf("beat %0d cleared_count %0d, predicted %0d",
                                    beats_seen, cleared_count_o, want));
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results owed",
               stall_cycles, pending_counts.size());
      $display("** hashed_page_table_engine: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int k = 0; k < KeyPool; k++) begin
      pool_va[k]   = $urandom;
      pool_vsid[k] = 20'($urandom);
    end
    send_idle_pct  = 13;
    recv_stall_pct = 13;
    test_field_extremes();
    test_flush_disabled();
    test_mask_aliasing();
    // phases: no idling, sender idle, receiver stalls, both, disabled table
    test_random_traffic(400, 2'd0, 1'b1, 0, 0);
    test_random_traffic(400, 2'd3, 1'b1, 86, 0);
    test_random_traffic(400, 2'd1, 1'b1, 0, 86);
    test_random_traffic(300, 2'd2, 1'b1, 13, 13);
    test_random_traffic(150, 2'd3, 1'b0, 13, 13);
    drain_results();
    if (error_count == 0) begin
      $display("** hashed_page_table_engine: PASSED **");
    end else begin
      $display("** hashed_page_table_engine: FAILED **");
    end
    $finish;
  end

endmodule
